[hdl/gmsh_pkg.sv]
// ----------------------------------------------------------------------------
// gmsh_pkg
// Shared widths, constants and types for the minimum start health grid block.
// ----------------------------------------------------------------------------
`default_nettype none

package gmsh_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int CELL_BITS   = 16;
    localparam int COL_BITS    = $clog2(MAX_COLUMNS);
    localparam int WIDTH_BITS  = 11;
    localparam int HEALTH_BITS = 31;
    // wide enough for saturated value minus the most negative gain
    localparam int CALC_BITS   = HEALTH_BITS + 2;
    // compare width for column count against the row width register
    localparam int CMP_BITS    = (COL_BITS + 1 > WIDTH_BITS) ? COL_BITS + 1 : WIDTH_BITS;

    localparam logic [HEALTH_BITS-1:0] SAT_MAX    = '1;
    localparam logic [HEALTH_BITS-1:0] HEALTH_ONE = HEALTH_BITS'(1);

    typedef struct packed {
        logic signed [CELL_BITS-1:0] cell_gain;
        logic                        final_cell;
        logic [COL_BITS-1:0]         col;
        logic                        bottom;
    } cell_stage_t;

endpackage

`default_nettype wire

[hdl/gmsh_ram.sv]
// ----------------------------------------------------------------------------
// gmsh_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gmsh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/grid_min_start_health_dp.sv]
// ----------------------------------------------------------------------------
// grid_min_start_health_dp
// Least starting health across a grid of signed cells, one row of values kept.
// ----------------------------------------------------------------------------
//
//  channel   signals                                    direction
//  -------   -----------------------------------------  ---------
//  cfg       cfg_write, cfg_data                        in
//  in        in_valid, in_stall, cell_gain, final_cell  in
//  out       out_valid, out_stall, min_start_health     out
//
//  one cell per cycle sustained while in_stall is low; a cell waits in the input
//  register while the row store read completes, then the result is registered
//  the row store (1024 x 31 ram) has one write and one read port, a same
//  column read and write on back to back cells is forwarded around it
//  reset zeroes position, sets the bottom row flag and clears pipeline valids; the store is not cleared
//  in_stall rises only while a final cell waits behind a stalled result
// ----------------------------------------------------------------------------
`default_nettype none

module grid_min_start_health_dp
    import gmsh_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [WIDTH_BITS-1:0]         cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [CELL_BITS-1:0]   cell_gain,
    input  wire logic                          final_cell,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [HEALTH_BITS-1:0]        min_start_health
);

    logic [WIDTH_BITS-1:0]  row_width_reg;
    logic [COL_BITS-1:0]    col_reg, col_next;
    logic                   bottom_reg, bottom_next;
    cell_stage_t            a_reg;
    logic                   a_valid_reg;
    logic [HEALTH_BITS-1:0] right_reg;
    logic                   bypass_reg, bypass_next;
    logic                   out_valid_reg;
    logic [HEALTH_BITS-1:0] result_reg;

    logic                   out_free;
    logic                   a_advance;
    logic                   accept;
    logic [CMP_BITS-1:0]    eff_width;
    logic [CMP_BITS-1:0]    col_plus;
    logic [HEALTH_BITS-1:0] ram_rdata;
    logic [HEALTH_BITS-1:0] below, right, need, val;
    logic signed [CALC_BITS-1:0] diff;

    // ------------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------------
    always_comb
    begin
        out_free  = !out_valid_reg || !out_stall;
        a_advance = a_valid_reg && (!a_reg.final_cell || out_free);
        in_stall  = a_valid_reg && !a_advance;
        accept    = in_valid && !in_stall;
    end

    // ------------------------------------------------------------------------
    // position tracking
    // ------------------------------------------------------------------------
    always_comb
    begin
        if (row_width_reg == '0)
        begin
            eff_width = CMP_BITS'(1);
        end
        else if (CMP_BITS'(row_width_reg) > CMP_BITS'(MAX_COLUMNS))
        begin
            eff_width = CMP_BITS'(MAX_COLUMNS);
        end
        else
        begin
            eff_width = CMP_BITS'(row_width_reg);
        end

        col_plus = CMP_BITS'(col_reg) + CMP_BITS'(1);

        priority if (final_cell)
        begin
            col_next    = '0;
            bottom_next = 1'b1;
        end
        else if (col_plus >= eff_width)
        begin
            col_next    = '0;
            bottom_next = 1'b0;
        end
        else
        begin
            col_next    = col_plus[COL_BITS-1:0];
            bottom_next = bottom_reg;
        end

        // the entry being written this edge is the one read for the new cell
        bypass_next = a_advance && (a_reg.col == col_reg);
    end

    // ------------------------------------------------------------------------
    // cell value
    // ------------------------------------------------------------------------
    always_comb
    begin
        if (a_reg.bottom)
        begin
            below = (a_reg.col == '0) ? HEALTH_ONE : SAT_MAX;
        end
        else
        begin
            below = bypass_reg ? right_reg : ram_rdata;
        end

        if (a_reg.col == '0)
        begin
            right = a_reg.bottom ? HEALTH_ONE : SAT_MAX;
        end
        else
        begin
            right = right_reg;
        end

        need = (below < right) ? below : right;
        diff = $signed({2'b00, need}) - CALC_BITS'(a_reg.cell_gain);

        priority if (diff[CALC_BITS-1] || diff == '0)
        begin
            val = HEALTH_ONE;
        end
        else if (diff[CALC_BITS-2])
        begin
            val = SAT_MAX;
        end
        else
        begin
            val = diff[HEALTH_BITS-1:0];
        end
    end

    gmsh_ram #(
        .WIDTH (HEALTH_BITS),
        .DEPTH (MAX_COLUMNS)
    ) u_row_store (
        .clk   (clk),
        .we    (a_advance),
        .waddr (a_reg.col),
        .wdata (val),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= WIDTH_BITS'(1);
            col_reg       <= '0;
            bottom_reg    <= 1'b1;
            a_valid_reg   <= 1'b0;
            right_reg     <= '0;
            bypass_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                row_width_reg <= cfg_data;
            end

            if (accept)
            begin
                col_reg    <= col_next;
                bottom_reg <= bottom_next;
                bypass_reg <= bypass_next;
            end

            if (accept || a_advance)
            begin
                a_valid_reg <= accept;
            end

            if (a_advance)
            begin
                right_reg <= a_reg.final_cell ? '0 : val;
            end

            if (out_free)
            begin
                out_valid_reg <= a_advance && a_reg.final_cell;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg.cell_gain  <= cell_gain;
            a_reg.final_cell <= final_cell;
            a_reg.col        <= col_reg;
            a_reg.bottom     <= bottom_reg;
        end

        if (out_free && a_advance && a_reg.final_cell)
        begin
            result_reg <= val;
        end
    end

    assign out_valid        = out_valid_reg;
    assign min_start_health = result_reg;

endmodule

`default_nettype wire

[hdl/gmsh_checker.sv]
// ----------------------------------------------------------------------------
// gmsh_checker
// Port level checks for the minimum start health grid block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module gmsh_checker
    import gmsh_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic                        in_stall,
    input  wire logic                        final_cell,
    input  wire logic                        out_valid,
    input  wire logic                        out_stall,
    input  wire logic [HEALTH_BITS-1:0]      min_start_health
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(min_start_health))
        else $error("stalled result changed");

    // a result is never below one
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> min_start_health != '0)
        else $error("result below one");

    // input backpressure only comes from a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // a new result follows a final cell transfer through the input register
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && final_cell, 2))
        else $error("result without final cell");

endmodule

bind grid_min_start_health_dp gmsh_checker u_gmsh_checker (.*);

`default_nettype wire
